// File: rtl/occupancy_grid_frame_update_defines.svh
// Assertion macros for the occupancy grid frame update block.
`ifndef OCCUPANCY_GRID_FRAME_UPDATE_DEFINES_SVH
`define OCCUPANCY_GRID_FRAME_UPDATE_DEFINES_SVH

// Checked outside reset.
`define OGFU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define OGFU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ogfu_pkg.sv
// Shared constants for the occupancy grid frame update block.
`timescale 1ns / 1ps
package ogfu_pkg;

  localparam int MAX_SIDE  = 256;
  localparam int MAX_CELLS = 65536;

  localparam int CELL_AW = $clog2(MAX_CELLS);
  localparam int CNT_W   = CELL_AW + 1;
  localparam int COORD_W = $clog2(MAX_SIDE);
  localparam int SIDE_W  = COORD_W + 1;

  localparam int XY_W   = 24;
  localparam int DIFF_W = XY_W + 1;
  localparam int INV_W  = 24;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int FRAC_W = 24;
  localparam int H_W    = 16;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 24;

  localparam logic [1:0] CMD_POINT  = 2'd0;
  localparam logic [1:0] CMD_COMMIT = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [CFG_AW-1:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_INV_RES   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_GRID_W    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_GRID_H    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_THRESHOLD = 3'd5;

  localparam logic [1:0] MARK_NONE = 2'd0;
  localparam logic [1:0] MARK_SEEN = 2'd1;
  localparam logic [1:0] MARK_HIGH = 2'd2;

endpackage

// File: rtl/occupancy_grid_frame_update.sv
// Occupancy grid frame update: bins points into a grid and commits frames.
//
// Input channel in_*: one item per command. cmd POINT maps (x, y) to a cell
// and marks it seen, or high when the height is above the threshold; cmd
// COMMIT writes every cell touched in the frame to the map and clears the
// marks; cmd READ returns the committed occupancy of one cell.
// Output channel out_*: exactly one item per input item, in order.
// A point passes S_DIFF, S_MUL, S_CHK and S_RMW, a read S_RD and S_RDW, a
// commit S_CMT, an unused command none of these, before S_OUT. One item is
// in flight at a time; the next is taken once the previous result sits in
// the output register. The commit walk is one touched cell per cycle, through
// registered reads of the touched list and the cell memory and a write back.
// Reset (rst_n low, synchronous) restores the registers and then sweeps the
// cell memory clean, one cell per cycle, with in_stall high; configuration
// writes are taken during the sweep.
// A stalled output holds its item; processing of the next item stops at its
// final step until the output register is free.
`timescale 1ns / 1ps
module occupancy_grid_frame_update import ogfu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_AW-1:0]        cfg_index,
  input  logic [CFG_DW-1:0]        cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_cmd,
  input  logic signed [XY_W-1:0]   in_point_x,
  input  logic signed [XY_W-1:0]   in_point_y,
  input  logic signed [H_W-1:0]    in_point_height,
  input  logic [CELL_AW-1:0]       in_read_index,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CELL_AW-1:0]       out_cell_index,
  output logic                     out_in_bounds,
  output logic                     out_occupied,
  output logic [CNT_W-1:0]         out_touched_count
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIFF, S_MUL, S_CHK, S_RMW, S_RD, S_RDW, S_CMT, S_OUT
  } state_t;

  // configuration
  logic signed [XY_W-1:0] origin_x_r, origin_y_r;
  logic [INV_W-1:0]       inv_res_r;
  logic [SIDE_W-1:0]      grid_w_r, grid_h_r;
  logic signed [H_W-1:0]  thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      inv_res_r  <= INV_W'(655360);
      grid_w_r   <= SIDE_W'(256);
      grid_h_r   <= SIDE_W'(256);
      thr_r      <= H_W'(77);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:  origin_x_r <= cfg_wdata[XY_W-1:0];
        REG_ORIGIN_Y:  origin_y_r <= cfg_wdata[XY_W-1:0];
        REG_INV_RES:   inv_res_r  <= cfg_wdata[INV_W-1:0];
        REG_GRID_W:    grid_w_r   <= cfg_wdata[SIDE_W-1:0];
        REG_GRID_H:    grid_h_r   <= cfg_wdata[SIDE_W-1:0];
        REG_THRESHOLD: thr_r      <= cfg_wdata[H_W-1:0];
        default: ;
      endcase
    end
  end

  // cell memory: {occupied, frame mark}; touched list
  logic [2:0]          cell_mem [MAX_CELLS];
  logic [CELL_AW-1:0]  list_mem [MAX_CELLS];

  logic               mem_re, mem_we, list_we;
  logic [CELL_AW-1:0] mem_raddr, mem_waddr, list_raddr, list_waddr, list_wdata;
  logic [2:0]         mem_wdata, cell_q;
  logic [CELL_AW-1:0] list_q;

  always_ff @(posedge clk) begin
    if (mem_we) cell_mem[mem_waddr] <= mem_wdata;
    if (mem_re) cell_q <= cell_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (list_we) list_mem[list_waddr] <= list_wdata;
    list_q <= list_mem[list_raddr];
  end

  // control and datapath registers
  state_t                   state_r, state_nxt;
  logic [CELL_AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic signed [XY_W-1:0]   pt_x_r, pt_x_nxt, pt_y_r, pt_y_nxt;
  logic signed [H_W-1:0]    pt_h_r, pt_h_nxt;
  logic [CELL_AW-1:0]       rd_idx_r, rd_idx_nxt;
  logic signed [DIFF_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [PROD_W-1:0] prx_r, prx_nxt, pry_r, pry_nxt;
  logic [CELL_AW-1:0]       idx_r, idx_nxt;
  logic                     inb_r, inb_nxt;
  logic [CNT_W-1:0]         total_r, total_nxt;
  logic [CNT_W-1:0]         walk_r, walk_nxt;
  logic                     v1_r, v1_nxt, v2_r, v2_nxt;
  logic [CELL_AW-1:0]       wb_addr_r, wb_addr_nxt;
  logic [CELL_AW-1:0]       res_cell_r, res_cell_nxt;
  logic                     res_inb_r, res_inb_nxt, res_occ_r, res_occ_nxt;
  logic [CNT_W-1:0]         res_cnt_r, res_cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [CELL_AW-1:0]       out_cell_r, out_cell_nxt;
  logic                     out_inb_r, out_inb_nxt, out_occ_r, out_occ_nxt;
  logic [CNT_W-1:0]         out_cnt_r, out_cnt_nxt;

  // cell coordinate and bounds
  logic signed [PROD_W-FRAC_W-1:0] cx, cy;
  logic [SIDE_W-1:0]   w_eff, h_eff;
  logic                cx_ok, cy_ok, in_grid;
  logic [CNT_W-1:0]    idx_full;
  logic [1:0]          mark;
  logic                new_entry, is_high, issue;
  logic [1:0]          new_mark;

  always_comb begin
    cx = prx_r[PROD_W-1:FRAC_W];
    cy = pry_r[PROD_W-1:FRAC_W];
    w_eff = (grid_w_r > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : grid_w_r;
    h_eff = (grid_h_r > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : grid_h_r;
    cx_ok = !cx[PROD_W-FRAC_W-1] &&
            (cx[PROD_W-FRAC_W-2:0] < (PROD_W-FRAC_W-1)'(w_eff));
    cy_ok = !cy[PROD_W-FRAC_W-1] &&
            (cy[PROD_W-FRAC_W-2:0] < (PROD_W-FRAC_W-1)'(h_eff));
    idx_full = CNT_W'(cy[COORD_W-1:0]) * CNT_W'(w_eff) + CNT_W'(cx[COORD_W-1:0]);
    in_grid = cx_ok && cy_ok && (idx_full < CNT_W'(MAX_CELLS));
    mark = cell_q[1:0];
    new_entry = (mark == MARK_NONE);
    is_high = (pt_h_r > thr_r);
    new_mark = is_high ? MARK_HIGH : (new_entry ? MARK_SEEN : mark);
    issue = (walk_r < total_r);
  end

  always_comb begin
    state_nxt = state_r;
    clr_cnt_nxt = clr_cnt_r;
    pt_x_nxt = pt_x_r;
    pt_y_nxt = pt_y_r;
    pt_h_nxt = pt_h_r;
    rd_idx_nxt = rd_idx_r;
    dx_nxt = dx_r;
    dy_nxt = dy_r;
    prx_nxt = prx_r;
    pry_nxt = pry_r;
    idx_nxt = idx_r;
    inb_nxt = inb_r;
    total_nxt = total_r;
    walk_nxt = walk_r;
    v1_nxt = 1'b0;
    v2_nxt = 1'b0;
    wb_addr_nxt = wb_addr_r;
    res_cell_nxt = res_cell_r;
    res_inb_nxt = res_inb_r;
    res_occ_nxt = res_occ_r;
    res_cnt_nxt = res_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_cell_nxt = out_cell_r;
    out_inb_nxt = out_inb_r;
    out_occ_nxt = out_occ_r;
    out_cnt_nxt = out_cnt_r;

    mem_re = 1'b0;
    mem_raddr = idx_full[CELL_AW-1:0];
    mem_we = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = {cell_q[2], new_mark};
    list_we = 1'b0;
    list_raddr = walk_r[CELL_AW-1:0];
    list_waddr = total_r[CELL_AW-1:0];
    list_wdata = idx_r;

    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CELL_AW'(MAX_CELLS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          pt_x_nxt = in_point_x;
          pt_y_nxt = in_point_y;
          pt_h_nxt = in_point_height;
          rd_idx_nxt = in_read_index;
          res_cell_nxt = '0;
          res_inb_nxt = 1'b0;
          res_occ_nxt = 1'b0;
          res_cnt_nxt = total_r;
          walk_nxt = '0;
          case (in_cmd)
            CMD_POINT:  state_nxt = S_DIFF;
            CMD_COMMIT: state_nxt = S_CMT;
            CMD_READ:   state_nxt = S_RD;
            default:    state_nxt = S_OUT;
          endcase
        end
      end
      S_DIFF: begin
        dx_nxt = DIFF_W'(pt_x_r) - DIFF_W'(origin_x_r);
        dy_nxt = DIFF_W'(pt_y_r) - DIFF_W'(origin_y_r);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prx_nxt = dx_r * $signed({1'b0, inv_res_r});
        pry_nxt = dy_r * $signed({1'b0, inv_res_r});
        state_nxt = S_CHK;
      end
      S_CHK: begin
        idx_nxt = idx_full[CELL_AW-1:0];
        inb_nxt = in_grid;
        mem_re = in_grid;
        state_nxt = S_RMW;
      end
      S_RMW: begin
        if (inb_r) begin
          mem_we = 1'b1;
          if (new_entry && (total_r < CNT_W'(MAX_CELLS))) begin
            list_we = 1'b1;
            total_nxt = total_r + 1'b1;
          end
          res_cell_nxt = idx_r;
          res_inb_nxt = 1'b1;
        end
        res_cnt_nxt = total_nxt;
        state_nxt = S_OUT;
      end
      S_RD: begin
        mem_re = 1'b1;
        mem_raddr = rd_idx_r;
        state_nxt = S_RDW;
      end
      S_RDW: begin
        res_cell_nxt = rd_idx_r;
        res_occ_nxt = cell_q[2];
        state_nxt = S_OUT;
      end
      S_CMT: begin
        // list read -> cell read -> write back; touched cells are distinct
        if (issue) begin
          walk_nxt = walk_r + 1'b1;
          v1_nxt = 1'b1;
        end
        if (v1_r) begin
          mem_re = 1'b1;
          mem_raddr = list_q;
          wb_addr_nxt = list_q;
          v2_nxt = 1'b1;
        end
        if (v2_r) begin
          mem_we = 1'b1;
          mem_waddr = wb_addr_r;
          mem_wdata = {(mark == MARK_HIGH), MARK_NONE};
        end
        if (!issue && !v1_r && !v2_r) begin
          res_cnt_nxt = total_r;
          total_nxt = '0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt = res_cell_r;
          out_inb_nxt = res_inb_r;
          out_occ_nxt = res_occ_r;
          out_cnt_nxt = res_cnt_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      total_r     <= '0;
      walk_r      <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      total_r     <= total_nxt;
      walk_r      <= walk_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pt_x_r     <= pt_x_nxt;
    pt_y_r     <= pt_y_nxt;
    pt_h_r     <= pt_h_nxt;
    rd_idx_r   <= rd_idx_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    prx_r      <= prx_nxt;
    pry_r      <= pry_nxt;
    idx_r      <= idx_nxt;
    inb_r      <= inb_nxt;
    wb_addr_r  <= wb_addr_nxt;
    res_cell_r <= res_cell_nxt;
    res_inb_r  <= res_inb_nxt;
    res_occ_r  <= res_occ_nxt;
    res_cnt_r  <= res_cnt_nxt;
    out_cell_r <= out_cell_nxt;
    out_inb_r  <= out_inb_nxt;
    out_occ_r  <= out_occ_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_cell_index    = out_cell_r;
  assign out_in_bounds     = out_inb_r;
  assign out_occupied      = out_occ_r;
  assign out_touched_count = out_cnt_r;

endmodule

// File: rtl/ogfu_checker.sv
// Port-level checks for the occupancy grid frame update block, with bind.
`timescale 1ns / 1ps
`include "occupancy_grid_frame_update_defines.svh"
module ogfu_checker import ogfu_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_in_bounds,
  input logic               out_occupied,
  input logic [CNT_W-1:0]   out_touched_count
);

  `OGFU_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `OGFU_ASSERT(a_point_unoccupied, out_valid && out_in_bounds |-> !out_occupied, "point result shows occupancy")
  `OGFU_ASSERT(a_count_range, out_valid |-> !(out_touched_count[CNT_W-1] && (out_touched_count[CNT_W-2:0] != '0)), "touched count above cell count")
  `OGFU_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "second item taken while one is in flight")
  `OGFU_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result after reset")

endmodule

bind occupancy_grid_frame_update ogfu_checker u_ogfu_checker (.*);

// File: dv/occupancy_grid_frame_update_tb.sv
// Self-checking testbench for the occupancy grid frame update block.
`timescale 1ns / 1ps
import ogfu_pkg::*;

typedef struct packed {
  bit [CELL_AW-1:0] cell_index;
  bit               in_bounds;
  bit               occupied;
  bit [CNT_W-1:0]   touched_count;
} cell_report_t;

class grid_cell_tracker;
  longint org_x, org_y, inv_res, thr;
  int     gw, gh;
  bit       occ_map [MAX_CELLS];
  bit [1:0] marks [MAX_CELLS];
  bit [CELL_AW-1:0] touched [$];
  cell_report_t due_reports [$];
  int errors, n_checked, n_points, n_hits, n_commits, n_reads, n_occ_reads, n_unused;

  function new();
    org_x = 0;
    org_y = 0;
    inv_res = 655360;
    gw = 256;
    gh = 256;
    thr = 77;
  endfunction

  function void load_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    case (idx)
      REG_ORIGIN_X:  org_x = longint'($signed(val));
      REG_ORIGIN_Y:  org_y = longint'($signed(val));
      REG_INV_RES:   inv_res = longint'(val);
      REG_GRID_W:    gw = int'(val[SIDE_W-1:0]);
      REG_GRID_H:    gh = int'(val[SIDE_W-1:0]);
      REG_THRESHOLD: thr = longint'($signed(val[H_W-1:0]));
      default: ;
    endcase
  endfunction

  function int due();
    return due_reports.size();
  endfunction

  // Predicts the result of one accepted item and advances the map state.
  function void take_item(logic [1:0] cmd, logic [XY_W-1:0] px, logic [XY_W-1:0] py,
                          logic [H_W-1:0] ph, logic [CELL_AW-1:0] ridx);
    longint dx, dy, cx, cy, idx;
    int w, ht;
    cell_report_t r;
    r = '{default: '0};
    case (cmd)
      CMD_POINT: begin
        n_points++;
        dx = longint'($signed(px)) - org_x;
        dy = longint'($signed(py)) - org_y;
        cx = (dx * inv_res) >>> FRAC_W;
        cy = (dy * inv_res) >>> FRAC_W;
        w = (gw > MAX_SIDE) ? MAX_SIDE : gw;
        ht = (gh > MAX_SIDE) ? MAX_SIDE : gh;
        if (cx >= 0 && cy >= 0 && cx < w && cy < ht) begin
          idx = cy * w + cx;
          if (idx < MAX_CELLS) begin
            if (marks[idx] == MARK_NONE) begin
              marks[idx] = MARK_SEEN;
              if (touched.size() < MAX_CELLS)
                touched.insert(touched.size(), idx[CELL_AW-1:0]);
            end
            if (longint'($signed(ph)) > thr) marks[idx] = MARK_HIGH;
            r.cell_index = idx[CELL_AW-1:0];
            r.in_bounds = 1'b1;
            n_hits++;
          end
        end
        r.touched_count = CNT_W'(touched.size());
      end
      CMD_COMMIT: begin
        n_commits++;
        foreach (touched[i]) begin
          occ_map[touched[i]] = (marks[touched[i]] == MARK_HIGH);
          marks[touched[i]] = MARK_NONE;
        end
        r.touched_count = CNT_W'(touched.size());
        touched.delete();
      end
      CMD_READ: begin
        n_reads++;
        r.cell_index = ridx;
        r.occupied = occ_map[ridx];
        if (r.occupied) n_occ_reads++;
        r.touched_count = CNT_W'(touched.size());
      end
      default: begin
        n_unused++;
        r.touched_count = CNT_W'(touched.size());
      end
    endcase
    due_reports.insert(due_reports.size(), r);
  endfunction

  function void note_mismatch(string s);
    errors++;
    if (errors <= 10) $display("ERROR: %s", s);
  endfunction

  function void match_report(logic [CELL_AW-1:0] cell_idx, logic inb, logic occ,
                             logic [CNT_W-1:0] cnt);
    cell_report_t e;
    if (due_reports.size() == 0) begin
      note_mismatch($sformatf("unexpected result: cell %0d inb %0b occ %0b count %0d",
                              cell_idx, inb, occ, cnt));
      return;
    end
    e = due_reports.pop_front();
    n_checked++;
    if (cell_idx !== e.cell_index || inb !== e.in_bounds || occ !== e.occupied ||
        cnt !== e.touched_count)
      note_mismatch($sformatf(
        "result %0d: exp cell %0d inb %0b occ %0b count %0d, got %0d %0b %0b %0d",
        n_checked, e.cell_index, e.in_bounds, e.occupied, e.touched_count,
        cell_idx, inb, occ, cnt));
  endfunction
endclass

module occupancy_grid_frame_update_tb;
  localparam int     CYCLE_LIMIT = 1000000;
  localparam longint Q24 = 64'sd16777216;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_AW-1:0]      cfg_index;
  logic [CFG_DW-1:0]      cfg_wdata;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             in_cmd;
  logic signed [XY_W-1:0] in_point_x;
  logic signed [XY_W-1:0] in_point_y;
  logic signed [H_W-1:0]  in_point_height;
  logic [CELL_AW-1:0]     in_read_index;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [CELL_AW-1:0]     out_cell_index;
  logic                   out_in_bounds;
  logic                   out_occupied;
  logic [CNT_W-1:0]       out_touched_count;

  grid_cell_tracker sb;
  int send_idle_pct = 16;
  int recv_stall_pct = 83;
  int items_sent = 0;
  int n_settings = 1;
  int cycles = 0;

  occupancy_grid_frame_update dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d results outstanding", cycles, sb.due());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      sb.match_report(out_cell_index, out_in_bounds, out_occupied, out_touched_count);

  task automatic send_item(input logic [1:0] cmd, input logic [XY_W-1:0] px,
                           input logic [XY_W-1:0] py, input logic [H_W-1:0] ph,
                           input logic [CELL_AW-1:0] ridx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_point_x <= px;
    in_point_y <= py;
    in_point_height <= ph;
    in_read_index <= ridx;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.take_item(cmd, px, py, ph, ridx);
    items_sent++;
    if (items_sent < 370) begin
      send_idle_pct = 16;
      recv_stall_pct = 83;
    end else if (items_sent < 740) begin
      send_idle_pct = 83;
      recv_stall_pct = 16;
    end else begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (sb.due() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DW-1:0];
    @(posedge clk);
    sb.load_reg(idx, value[CFG_DW-1:0]);
  endtask

  task automatic apply_settings(input int ox, input int oy, input int inv,
                                input int w, input int h, input int th);
    wait_all_results();
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_INV_RES, inv);
    write_reg(REG_GRID_W, w);
    write_reg(REG_GRID_H, h);
    write_reg(REG_THRESHOLD, th);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Coordinate that lands in cell c along one axis, saturated to the field range; random when inv is zero.
  function automatic logic [XY_W-1:0] aim(input int c, input longint org, input longint inv);
    longint lo, hi, p;
    if (inv == 0) return XY_W'($urandom);
    lo = (longint'(c) * Q24 + inv - 1) / inv;
    hi = ((longint'(c) + 1) * Q24 + inv - 1) / inv - 1;
    if (hi < lo) hi = lo;
    p = org + lo + longint'($urandom_range(32'(hi - lo), 0));
    if (p > 64'sd8388607) p = 64'sd8388607;
    if (p < -64'sd8388608) p = -64'sd8388608;
    return p[XY_W-1:0];
  endfunction

  task automatic run_phase(input int n, input bit leave_open);
    int pool_x [16];
    int pool_y [16];
    int w, ht, k, sel, cx, cy;
    logic [1:0] cmd;
    logic [XY_W-1:0] px, py;
    logic [H_W-1:0] ph;
    logic [CELL_AW-1:0] ridx;
    w = (sb.gw > MAX_SIDE) ? MAX_SIDE : sb.gw;
    ht = (sb.gh > MAX_SIDE) ? MAX_SIDE : sb.gh;
    if (w == 0) w = 1;
    if (ht == 0) ht = 1;
    foreach (pool_x[i]) begin
      pool_x[i] = $urandom_range(w - 1);
      pool_y[i] = $urandom_range(ht - 1);
    end
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (leave_open && i >= n - 5) sel = 50;
      k = $urandom_range(15);
      cx = pool_x[k];
      cy = pool_y[k];
      if ($urandom_range(3) == 0) begin
        cx = $urandom_range(w - 1);
        cy = $urandom_range(ht - 1);
      end
      if ($urandom_range(24) == 0) cx = w;
      if ($urandom_range(24) == 0) cy = ht;
      px = aim(cx, sb.org_x, sb.inv_res);
      py = aim(cy, sb.org_y, sb.inv_res);
      ph = $urandom_range(1) ? H_W'(sb.thr + $urandom_range(4) - 2) : H_W'($urandom);
      ridx = CELL_AW'($urandom);
      cmd = CMD_POINT;
      if (sel < 6) begin
        px = XY_W'($urandom);
        py = XY_W'($urandom);
      end else if (sel < 18) begin
        cmd = CMD_READ;
        if (sel < 13) ridx = CELL_AW'(cy * w + cx);
      end else if (sel < 27) begin
        cmd = CMD_COMMIT;
      end else if (sel < 30) begin
        cmd = CMD_NONE;
        px = XY_W'($urandom);
        py = XY_W'($urandom);
      end
      send_item(cmd, px, py, ph, ridx);
    end
  endtask

  initial begin
    sb = new();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_cmd <= CMD_NONE;
    in_point_x <= '0;
    in_point_y <= '0;
    in_point_height <= '0;
    in_read_index <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: 0.0390625 cells per coordinate unit, full 256 x 256 grid, threshold 77
    send_item(CMD_READ, '0, '0, '0, 16'd0);
    send_item(CMD_READ, '0, '0, '0, 16'hffff);
    send_item(CMD_POINT, 24'd0, 24'd0, 16'd77, '0);
    send_item(CMD_POINT, 24'd0, 24'd0, 16'd78, '0);
    send_item(CMD_POINT, 24'd6553, 24'd6553, 16'h8000, '0);
    send_item(CMD_POINT, 24'd6554, 24'd10, 16'd0, '0);
    send_item(CMD_POINT, 24'hffffff, 24'd10, 16'd0, '0);
    send_item(CMD_POINT, 24'h7fffff, 24'h800000, 16'h7fff, '0);
    send_item(CMD_POINT, 24'd1000, 24'd2000, 16'h7fff, '0);
    send_item(CMD_NONE, 24'h5a5a5a, 24'ha5a5a5, 16'h1234, 16'h4321);
    send_item(CMD_READ, '0, '0, '0, 16'd0);
    send_item(CMD_COMMIT, '0, '0, '0, '0);
    send_item(CMD_READ, '0, '0, '0, 16'd0);
    send_item(CMD_READ, '0, '0, '0, 16'hffff);
    send_item(CMD_READ, '0, '0, '0, 16'd1795);
    send_item(CMD_COMMIT, '0, '0, '0, '0);
    send_item(CMD_POINT, 24'd0, 24'd0, 16'h8000, '0);
    send_item(CMD_COMMIT, '0, '0, '0, '0);
    send_item(CMD_READ, '0, '0, '0, 16'd0);
    send_item(CMD_POINT, 24'd6553, 24'd6553, 16'h7fff, '0);
    send_item(CMD_COMMIT, '0, '0, '0, '0);
    send_item(CMD_READ, '0, '0, '0, 16'hffff);

    apply_settings(-512, -256, 655360, 16, 12, 0);
    run_phase(180, 1'b0);
    apply_settings(-8388608, -8388608, 16777215, 256, 256, -32768);
    run_phase(150, 1'b0);
    apply_settings(-8388608, 8388607, 1, 511, 300, 32767);
    run_phase(80, 1'b0);
    apply_settings(123, -77, 0, 5, 7, 77);
    run_phase(60, 1'b0);
    apply_settings(0, 0, 655360, 0, 10, 0);
    run_phase(40, 1'b0);
    apply_settings(256, 512, 143417, 37, 1, -100);
    run_phase(150, 1'b1);
    // frame left open across this change
    apply_settings(-1000, 0, 1966080, 1, 256, 200);
    run_phase(200, 1'b0);
    apply_settings(0, 0, 655360, 256, 256, 77);
    run_phase(250, 1'b0);

    wait_all_results();
    repeat (20) @(posedge clk);
    $display("Ran %0d items: %0d points (%0d in grid), %0d commits, %0d reads (%0d occupied), %0d unused",
             items_sent, sb.n_points, sb.n_hits, sb.n_commits, sb.n_reads, sb.n_occ_reads,
             sb.n_unused);
    $display("%0d results checked over %0d register settings, %0d mismatches",
             sb.n_checked, n_settings, sb.errors);
    if (sb.errors == 0 && sb.due() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
